@@ hw/rtl/tcgw_pkg.sv @@
// Shared types and constants for the text console grid writer.
// Holds the command and result word structs, the sequencer state enum and register codes.
// No dependencies; the registers, sequencer and top use scoped names, the testbench imports it.
`default_nettype none

package tcgw_pkg;

	// default sizes of the character grid
	localparam int MAX_ROWS_DEF  = 32;
	localparam int MAX_SLOTS_DEF = 128;

	// field widths of the command and result words
	localparam int CMD_W    = 2;
	localparam int CHAR_W   = 16;
	localparam int RROW_W   = 5;
	localparam int RCOL_W   = 7;

	// configuration register widths and reset values
	localparam int ROWCFG_W  = 6;
	localparam int SLOTCFG_W = 8;
	localparam logic [ROWCFG_W-1:0]  ROWS_RST  = 6'd32;
	localparam logic [SLOTCFG_W-1:0] SLOTS_RST = 8'd128;

	// APB port geometry
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register select (byte address bit 2)
	localparam logic REG_ROWS  = 1'b0;
	localparam logic REG_SLOTS = 1'b1;

	// limit bus width, wide enough for the largest grid
	localparam int LIM_W = 8;

	// character codes
	localparam logic [CHAR_W-1:0] NEWLINE = 16'd10;
	localparam logic [CHAR_W-1:0] NUL     = 16'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_MARK  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [CHAR_W-1:0] char_code;
		logic [RROW_W-1:0] read_row;
		logic [RCOL_W-1:0] read_column;
	} in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_value;
		logic [RROW_W-1:0] cursor_row_now;
		logic [RCOL_W-1:0] cursor_column_now;
	} out_t;

	// last row and last slot in use, from the configuration registers
	typedef struct packed {
		logic [LIM_W-1:0] rows_last;
		logic [LIM_W-1:0] slots_last;
	} lim_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_BREAK,
		ST_ROWCLR,
		ST_PUT
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcgw_ram.sv @@
// Generic single-port RAM with registered read data.
// One write or read address per cycle; no dependencies.
`default_nettype none

module tcgw_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 4096,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/tcgw_inc.sv @@
// Shared increment-and-compare unit of the grid sequencer.
// Gives op + 1 and whether op has reached its last value; no dependencies.
`default_nettype none

module tcgw_inc #(
	parameter int W = 12
) (
	input  wire logic [W-1:0] op,
	input  wire logic [W-1:0] last,
	output logic      [W-1:0] sum,
	output logic              hit
);

	// one adder and one equality compare, shared by every sweep and cursor step
	assign sum = op + W'(1);
	assign hit = (op == last);

endmodule

`default_nettype wire

@@ hw/rtl/tcgw_regs.sv @@
// APB configuration registers of the grid writer: rows in use and line slots.
// Clamps both into the grid and reports the last row and slot; uses tcgw_pkg.
`default_nettype none

module tcgw_regs #(
	parameter int MAX_ROWS       = tcgw_pkg::MAX_ROWS_DEF,
	parameter int MAX_LINE_SLOTS = tcgw_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tcgw_pkg::PADDR_W-1:0] paddr,
	input  wire logic [tcgw_pkg::PDATA_W-1:0] pwdata,
	output logic      [tcgw_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	output tcgw_pkg::lim_t                    lim,
	output logic                              cfg_wr
);

	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int SNW = $clog2(MAX_LINE_SLOTS + 1);
	localparam int REW = (tcgw_pkg::ROWCFG_W > RNW) ? tcgw_pkg::ROWCFG_W : RNW;
	localparam int SEW = (tcgw_pkg::SLOTCFG_W > SNW) ? tcgw_pkg::SLOTCFG_W : SNW;

	logic [tcgw_pkg::ROWCFG_W-1:0]  rows_q;
	logic [tcgw_pkg::SLOTCFG_W-1:0] slots_q;
	logic [REW-1:0]                 rows_raw, rows_eff;
	logic [SEW-1:0]                 slots_raw, slots_eff;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= tcgw_pkg::ROWS_RST;
			slots_q <= tcgw_pkg::SLOTS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == tcgw_pkg::REG_SLOTS) begin
				slots_q <= pwdata[tcgw_pkg::SLOTCFG_W-1:0];
			end else begin
				rows_q <= pwdata[tcgw_pkg::ROWCFG_W-1:0];
			end
		end
	end

	// read back
	always_comb begin
		case (paddr[2])
			tcgw_pkg::REG_SLOTS: prdata = tcgw_pkg::PDATA_W'(slots_q);
			default:             prdata = tcgw_pkg::PDATA_W'(rows_q);
		endcase
	end

	// clamp into the grid that storage holds
	always_comb begin
		rows_raw  = REW'(rows_q);
		slots_raw = SEW'(slots_q);
		if (rows_raw == REW'(0)) begin
			rows_eff = REW'(1);
		end else if (rows_raw > REW'(MAX_ROWS)) begin
			rows_eff = REW'(MAX_ROWS);
		end else begin
			rows_eff = rows_raw;
		end
		if (slots_raw < SEW'(2)) begin
			slots_eff = SEW'(2);
		end else if (slots_raw > SEW'(MAX_LINE_SLOTS)) begin
			slots_eff = SEW'(MAX_LINE_SLOTS);
		end else begin
			slots_eff = slots_raw;
		end
	end

	assign lim.rows_last  = tcgw_pkg::LIM_W'(rows_eff - REW'(1));
	assign lim.slots_last = tcgw_pkg::LIM_W'(slots_eff - SEW'(1));

endmodule

`default_nettype wire

@@ hw/rtl/tcgw_ctrl.sv @@
// Sequencer of the grid writer: cursor, clearing sweeps and cell access.
// Drives the cell RAM and steps everything through the shared tcgw_inc unit; uses tcgw_pkg.
`default_nettype none

module tcgw_ctrl #(
	parameter  int MAX_ROWS       = tcgw_pkg::MAX_ROWS_DEF,
	parameter  int MAX_LINE_SLOTS = tcgw_pkg::MAX_SLOTS_DEF,
	localparam int COL_W  = $clog2(MAX_LINE_SLOTS),
	localparam int DEPTH  = MAX_ROWS * (2 ** COL_W),
	localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire tcgw_pkg::in_t               in_word,
	output logic                             busy,
	output logic                             done,
	output tcgw_pkg::out_t                   out_word,
	input  wire tcgw_pkg::lim_t              lim,
	input  wire logic                        cfg_wr,
	output logic                             ram_we,
	output logic      [RAM_AW-1:0]           ram_addr,
	output logic      [tcgw_pkg::CHAR_W-1:0] ram_wdata,
	input  wire logic [tcgw_pkg::CHAR_W-1:0] ram_rdata
);

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int W     = RAM_AW;
	localparam int RCW   = (tcgw_pkg::RROW_W > ROW_W) ? tcgw_pkg::RROW_W : ROW_W;
	localparam int CCW   = (tcgw_pkg::RCOL_W > COL_W) ? tcgw_pkg::RCOL_W : COL_W;

	tcgw_pkg::state_t            state_q, state_d;
	tcgw_pkg::in_t               item_q;
	logic [W-1:0]                ptr_q;
	logic [ROW_W-1:0]            row_q;
	logic [COL_W-1:0]            col_q;
	logic                        pend_q;
	logic                        put_after_q;
	logic                        done_q;
	logic [tcgw_pkg::CHAR_W-1:0] cell_q;

	logic [ROW_W-1:0]            rows_last;
	logic [COL_W-1:0]            slots_last;
	logic [W-1:0]                inc_op, inc_last, inc_sum;
	logic                        inc_hit;
	logic                        fin;
	logic                        in_range;
	logic                        is_nl, is_nul;
	logic [tcgw_pkg::CHAR_W-1:0] cell_val;

	assign rows_last  = ROW_W'(lim.rows_last);
	assign slots_last = COL_W'(lim.slots_last);
	assign is_nl      = (item_q.char_code == tcgw_pkg::NEWLINE);
	assign is_nul     = (item_q.char_code == tcgw_pkg::NUL);
	assign in_range   = (RCW'(item_q.read_row) <= RCW'(rows_last)) &&
	                    (CCW'(item_q.read_column) <= CCW'(slots_last));

	// operand select for the shared incrementer
	always_comb begin
		case (state_q)
			tcgw_pkg::ST_CLEAR: begin
				inc_op   = ptr_q;
				inc_last = W'(DEPTH - 1);
			end
			tcgw_pkg::ST_ROWCLR: begin
				inc_op   = W'(ptr_q[COL_W-1:0]);
				inc_last = W'(slots_last);
			end
			tcgw_pkg::ST_BREAK: begin
				inc_op   = W'(row_q);
				inc_last = W'(rows_last);
			end
			default: begin
				inc_op   = W'(col_q);
				inc_last = W'(slots_last);
			end
		endcase
	end

	tcgw_inc #(.W(W)) u_inc (
		.op   (inc_op),
		.last (inc_last),
		.sum  (inc_sum),
		.hit  (inc_hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcgw_pkg::ST_CLEAR: begin
				if (inc_hit) begin
					state_d = tcgw_pkg::ST_IDLE;
				end
			end
			tcgw_pkg::ST_IDLE: begin
				if (start) begin
					state_d = tcgw_pkg::ST_EXEC;
				end
			end
			tcgw_pkg::ST_EXEC: begin
				case (item_q.cmd)
					tcgw_pkg::CMD_WRITE: begin
						if (is_nl || (!is_nul && inc_hit)) begin
							state_d = tcgw_pkg::ST_BREAK;
						end else begin
							state_d = tcgw_pkg::ST_IDLE;
						end
					end
					tcgw_pkg::CMD_CLEAR: state_d = tcgw_pkg::ST_CLEAR;
					tcgw_pkg::CMD_READ:  state_d = tcgw_pkg::ST_READ;
					default:             state_d = tcgw_pkg::ST_IDLE;
				endcase
			end
			tcgw_pkg::ST_BREAK: state_d = tcgw_pkg::ST_ROWCLR;
			tcgw_pkg::ST_ROWCLR: begin
				if (inc_hit) begin
					state_d = put_after_q ? tcgw_pkg::ST_PUT : tcgw_pkg::ST_IDLE;
				end
			end
			default: state_d = tcgw_pkg::ST_IDLE;
		endcase
		// a register write wipes the grid
		if (cfg_wr) begin
			state_d = tcgw_pkg::ST_CLEAR;
		end
	end

	// RAM port, finish strobe and read value
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = RAM_AW'({row_q, col_q});
		ram_wdata = tcgw_pkg::NUL;
		fin       = 1'b0;
		cell_val  = tcgw_pkg::NUL;
		case (state_q)
			tcgw_pkg::ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = ptr_q;
				fin      = inc_hit & pend_q;
			end
			tcgw_pkg::ST_EXEC: begin
				case (item_q.cmd)
					tcgw_pkg::CMD_WRITE: begin
						ram_wdata = item_q.char_code;
						ram_we    = !is_nl && !is_nul && !inc_hit;
						fin       = is_nul || (!is_nl && !inc_hit);
					end
					tcgw_pkg::CMD_READ: begin
						ram_addr = RAM_AW'({ROW_W'(item_q.read_row),
						                    COL_W'(item_q.read_column)});
					end
					tcgw_pkg::CMD_MARK: begin
						ram_we    = 1'b1;
						ram_wdata = tcgw_pkg::NEWLINE;
						fin       = 1'b1;
					end
					default: ;
				endcase
			end
			tcgw_pkg::ST_READ: begin
				fin      = 1'b1;
				cell_val = in_range ? ram_rdata : tcgw_pkg::NUL;
			end
			tcgw_pkg::ST_BREAK: begin
				ram_we    = 1'b1;
				ram_wdata = tcgw_pkg::NEWLINE;
			end
			tcgw_pkg::ST_ROWCLR: begin
				ram_we   = 1'b1;
				ram_addr = RAM_AW'({row_q, ptr_q[COL_W-1:0]});
				fin      = inc_hit & !put_after_q;
			end
			tcgw_pkg::ST_PUT: begin
				ram_we    = 1'b1;
				ram_wdata = item_q.char_code;
				fin       = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers: state, cursor, sweep pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcgw_pkg::ST_CLEAR;
			ptr_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pend_q      <= 1'b0;
			put_after_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_wr) begin
				ptr_q  <= '0;
				row_q  <= '0;
				col_q  <= '0;
				pend_q <= 1'b0;
			end else begin
				case (state_q)
					tcgw_pkg::ST_CLEAR: begin
						ptr_q <= inc_sum;
						if (inc_hit) begin
							pend_q <= 1'b0;
						end
					end
					tcgw_pkg::ST_EXEC: begin
						case (item_q.cmd)
							tcgw_pkg::CMD_WRITE: begin
								if (is_nl) begin
									put_after_q <= 1'b0;
								end else if (!is_nul) begin
									if (inc_hit) begin
										put_after_q <= 1'b1;
									end else begin
										col_q <= COL_W'(inc_sum);
									end
								end
							end
							tcgw_pkg::CMD_CLEAR: begin
								ptr_q  <= '0;
								row_q  <= '0;
								col_q  <= '0;
								pend_q <= 1'b1;
							end
							default: ;
						endcase
					end
					tcgw_pkg::ST_BREAK: begin
						row_q <= inc_hit ? '0 : ROW_W'(inc_sum);
						col_q <= '0;
						ptr_q <= '0;
					end
					tcgw_pkg::ST_ROWCLR: ptr_q <= inc_sum;
					tcgw_pkg::ST_PUT:    col_q <= COL_W'(inc_sum);
					default: ;
				endcase
			end
		end
	end

	// command word and read value
	always_ff @(posedge clk) begin
		if (start && (state_q == tcgw_pkg::ST_IDLE)) begin
			item_q <= in_word;
		end
		if (fin) begin
			cell_q <= cell_val;
		end
	end

	assign busy                       = (state_q != tcgw_pkg::ST_IDLE);
	assign done                       = done_q;
	assign out_word.cell_value        = cell_q;
	assign out_word.cursor_row_now    = tcgw_pkg::RROW_W'(row_q);
	assign out_word.cursor_column_now = tcgw_pkg::RCOL_W'(col_q);

	// a result strobe is never followed directly by another
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held two cycles");

	// cursor stays inside the grid in use while waiting
	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcgw_pkg::ST_IDLE) |-> ((row_q <= rows_last) && (col_q <= slots_last)))
		else $error("cursor outside grid");

	// no cell write while waiting for a command
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcgw_pkg::ST_IDLE) |-> !ram_we) else $error("write while idle");

	// row clear never runs past the last slot
	a_rowclr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcgw_pkg::ST_ROWCLR) |-> (ptr_q[COL_W-1:0] <= slots_last))
		else $error("row clear past last slot");

endmodule

`default_nettype wire

@@ hw/rtl/text_console_grid_writer.sv @@
// Text console grid writer: plain character, mark and zero commands end in the execute
// step, read cell in a read step after it; newline writes the line-end mark, steps to the
// next row of the ring and clears it slot by slot; a character that wraps does the same
// and is then written. Clear-all: MAX_ROWS * 2**clog2(MAX_LINE_SLOTS) cells (4096), one
// cell per cycle. After reset and any register write the same clearing pass runs with
// busy high, commands are taken in idle only; the result strobe lasts one cycle, cannot stall.
`default_nettype none

module text_console_grid_writer #(
	parameter int MAX_ROWS       = tcgw_pkg::MAX_ROWS_DEF,
	parameter int MAX_LINE_SLOTS = tcgw_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire tcgw_pkg::in_t                in_word,
	output logic                              busy,
	output logic                              done,
	output tcgw_pkg::out_t                    out_word,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tcgw_pkg::PADDR_W-1:0] paddr,
	input  wire logic [tcgw_pkg::PDATA_W-1:0] pwdata,
	output logic      [tcgw_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);

	localparam int COL_W  = $clog2(MAX_LINE_SLOTS);
	localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);
	localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	tcgw_pkg::lim_t              lim;
	logic                        cfg_wr;
	logic                        ram_we;
	logic [RAM_AW-1:0]           ram_addr;
	logic [tcgw_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

	// configuration registers
	tcgw_regs #(
		.MAX_ROWS       (MAX_ROWS),
		.MAX_LINE_SLOTS (MAX_LINE_SLOTS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.lim     (lim),
		.cfg_wr  (cfg_wr)
	);

	// sequencer
	tcgw_ctrl #(
		.MAX_ROWS       (MAX_ROWS),
		.MAX_LINE_SLOTS (MAX_LINE_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.in_word   (in_word),
		.busy      (busy),
		.done      (done),
		.out_word  (out_word),
		.lim       (lim),
		.cfg_wr    (cfg_wr),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	// character cell storage
	tcgw_ram #(
		.WIDTH (tcgw_pkg::CHAR_W),
		.DEPTH (DEPTH)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for text_console_grid_writer: directed and random command words,
// register writes over APB between phases, and an in-bench model of the character grid.
// Depends on tcgw_pkg (word structs, command enum, register select codes) and the RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcgw_pkg::*;

	localparam int QUIET_LIMIT     = 30000;	// well above a clear-all
	localparam int TAIL_CYCLES     = 200;	// longer than the slowest line break
	localparam int PHASES          = 10;
	localparam int WORDS_PER_PHASE = 183;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	in_t                 in_word = '0;
	logic                busy;
	logic                done;
	out_t                out_word;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [PADDR_W-1:0]  paddr   = '0;
	logic [PDATA_W-1:0]  pwdata  = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	in_t  pending_words[$];
	out_t cursor_reports[$];
	int   sender_idle_pct = 0;
	logic word_accepted   = 1'b0;
	int   mismatch_count  = 0;
	int   quiet_cycles    = 0;

	// model of the console: grid, cursor and the two registers
	logic [CHAR_W-1:0]    grid [MAX_ROWS_DEF][MAX_SLOTS_DEF];
	int                   cur_row;
	int                   cur_col;
	logic [ROWCFG_W-1:0]  rows_reg;
	logic [SLOTCFG_W-1:0] slots_reg;

	always #5 clk = ~clk;

	text_console_grid_writer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.in_word  (in_word),
		.busy     (busy),
		.done     (done),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// register values outside the legal range saturate
	function automatic int rows_in_effect(logic [ROWCFG_W-1:0] v);
		if (v < 1) return 1;
		if (v > MAX_ROWS_DEF) return MAX_ROWS_DEF;
		return int'(v);
	endfunction

	function automatic int slots_in_effect(logic [SLOTCFG_W-1:0] v);
		if (v < 2) return 2;
		if (v > MAX_SLOTS_DEF) return MAX_SLOTS_DEF;
		return int'(v);
	endfunction

	function void wipe_grid();
		foreach (grid[r, c]) grid[r][c] = '0;
		cur_row = 0;
		cur_col = 0;
	endfunction

	// line-end mark at the cursor, step to the next row of the ring and blank it
	function void break_line();
		grid[cur_row][cur_col] = NEWLINE;
		cur_row = (cur_row + 1) % rows_in_effect(rows_reg);
		cur_col = 0;
		for (int c = 0; c < MAX_SLOTS_DEF; c++) grid[cur_row][c] = '0;
	endfunction

	// applies one command word to the grid model, returns the result word it yields
	function automatic out_t advance_console(in_t w);
		out_t r = '0;
		case (w.cmd)
			CMD_WRITE: begin
				if (w.char_code == NEWLINE) begin
					break_line();
				end else if (w.char_code != NUL) begin
					// the last slot is reserved, so a full line breaks first
					if (cur_col >= slots_in_effect(slots_reg) - 1) break_line();
					grid[cur_row][cur_col] = w.char_code;
					cur_col++;
				end
			end
			CMD_CLEAR: wipe_grid();
			CMD_READ: begin
				if (w.read_row < rows_in_effect(rows_reg) &&
				    w.read_column < slots_in_effect(slots_reg))
					r.cell_value = grid[w.read_row][w.read_column];
			end
			default: grid[cur_row][cur_col] = NEWLINE;
		endcase
		r.cursor_row_now    = RROW_W'(cur_row);
		r.cursor_column_now = RCOL_W'(cur_col);
		return r;
	endfunction

	// driver: a word stays on the port until it is taken
	always @(negedge clk) begin
		if (!start || word_accepted) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				start   <= 1'b1;
				in_word <= pending_words.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: checks results, tracks register accesses, predicts accepted words
	always @(posedge clk or negedge arst_n) begin
		out_t                wanted;
		logic [PDATA_W-1:0]  reg_value;
		if (!arst_n) begin
			rows_reg  = ROWS_RST;
			slots_reg = SLOTS_RST;
			wipe_grid();
			word_accepted <= 1'b0;
			quiet_cycles = 0;
		end else begin
			// a result always belongs to a word taken at an earlier edge
			if (done) begin
				if (cursor_reports.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result word: value %h row %0d col %0d",
							out_word.cell_value, out_word.cursor_row_now,
							out_word.cursor_column_now);
				end else begin
					wanted = cursor_reports.pop_front();
					if (out_word.cell_value !== wanted.cell_value ||
					    out_word.cursor_row_now !== wanted.cursor_row_now ||
					    out_word.cursor_column_now !== wanted.cursor_column_now) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"result mismatch: expected value %h row %0d col %0d,",
								" got value %h row %0d col %0d"},
								wanted.cell_value, wanted.cursor_row_now,
								wanted.cursor_column_now, out_word.cell_value,
								out_word.cursor_row_now, out_word.cursor_column_now);
					end
				end
			end

			// register access; a write also clears the grid and homes the cursor
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_SLOTS) slots_reg = pwdata[SLOTCFG_W-1:0];
					else rows_reg = pwdata[ROWCFG_W-1:0];
					wipe_grid();
				end else begin
					reg_value = (paddr[2] == REG_SLOTS) ? PDATA_W'(slots_reg) :
						PDATA_W'(rows_reg);
					if (prdata !== reg_value) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("register read at %h: expected %h, got %h",
								paddr, reg_value, prdata);
					end
				end
			end

			if (start && !busy) cursor_reports.push_back(advance_console(in_word));
			word_accepted <= start && !busy;

			// watchdog on cycles with no traffic at all
			if (done || (psel && penable) || (start && !busy)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	// block idle: nothing queued, nothing on the port, nothing outstanding
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_words.size() != 0 || start || cursor_reports.size() != 0 || busy);
	endtask

	task automatic cfg_access(bit is_write, logic sel, logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// unused fields get random values
	task automatic queue_word(cmd_t c, logic [CHAR_W-1:0] code, logic [RROW_W-1:0] r,
		logic [RCOL_W-1:0] col);
		in_t w;
		w.cmd         = c;
		w.char_code   = (c == CMD_WRITE) ? code : CHAR_W'($urandom);
		w.read_row    = (c == CMD_READ) ? r : RROW_W'($urandom);
		w.read_column = (c == CMD_READ) ? col : RCOL_W'($urandom);
		pending_words.push_back(w);
	endtask

	task automatic run_phase(int p, logic [ROWCFG_W-1:0] rows_v, logic [SLOTCFG_W-1:0] slots_v,
		bit write_cfg);
		int   counted = 0;
		int   pick;
		int   rows_u;
		int   slots_u;
		in_t  w;
		wait_drained();
		if (write_cfg) begin
			cfg_access(1'b1, REG_ROWS, PDATA_W'(rows_v));
			wait_drained();
			cfg_access(1'b1, REG_SLOTS, PDATA_W'(slots_v));
			wait_drained();
		end
		cfg_access(1'b0, REG_ROWS, '0);
		cfg_access(1'b0, REG_SLOTS, '0);
		@(posedge clk);
		rows_u  = rows_in_effect(rows_v);
		slots_u = slots_in_effect(slots_v);
		case (p % 4)
			1: sender_idle_pct = 83;
			3: sender_idle_pct = 7;
			default: sender_idle_pct = 0;
		endcase

		// full-size grid: character extremes, ignored zero, mark, reads, clear
		if (p == 0) begin
			queue_word(CMD_WRITE, 16'h0041, 0, 0);
			queue_word(CMD_WRITE, NUL, 0, 0);
			queue_word(CMD_WRITE, 16'hFFFF, 0, 0);
			queue_word(CMD_WRITE, 16'h0001, 0, 0);
			queue_word(CMD_MARK, 0, 0, 0);
			queue_word(CMD_READ, 0, 5'd0, 7'd1);
			queue_word(CMD_WRITE, NEWLINE, 0, 0);
			queue_word(CMD_WRITE, 16'h0042, 0, 0);
			queue_word(CMD_READ, 0, 5'd0, 7'd3);
			queue_word(CMD_READ, 0, 5'd31, 7'd127);
			queue_word(CMD_CLEAR, 0, 0, 0);
			queue_word(CMD_READ, 0, 5'd0, 7'd0);
		end

		// 2 rows of 3 slots: mark in the reserved slot, wrap, row ring, reads outside
		if (p == 1) begin
			queue_word(CMD_WRITE, 16'h0078, 0, 0);
			queue_word(CMD_WRITE, 16'h0079, 0, 0);
			queue_word(CMD_MARK, 0, 0, 0);
			queue_word(CMD_READ, 0, 5'd0, 7'd2);
			queue_word(CMD_WRITE, 16'h007A, 0, 0);
			queue_word(CMD_READ, 0, 5'd5, 7'd100);
			queue_word(CMD_READ, 0, 5'd1, 7'd2);
			queue_word(CMD_WRITE, NEWLINE, 0, 0);
			queue_word(CMD_READ, 0, 5'd0, 7'd0);
			queue_word(CMD_READ, 0, 5'd2, 7'd0);
			queue_word(CMD_READ, 0, 5'd0, 7'd3);
		end

		// random mix: mostly text and newlines, reads mostly inside the grid
		while (counted < WORDS_PER_PHASE) begin
			pick          = $urandom_range(999);
			w.cmd         = CMD_WRITE;
			w.char_code   = CHAR_W'($urandom);
			w.read_row    = RROW_W'($urandom);
			w.read_column = RCOL_W'($urandom);
			if (pick < 10) begin
				w.cmd = CMD_CLEAR;
			end else if (pick < 160) begin
				w.cmd         = CMD_READ;
				w.read_row    = RROW_W'($urandom_range(rows_u - 1));
				w.read_column = RCOL_W'($urandom_range(slots_u - 1));
			end else if (pick < 210) begin
				w.cmd = CMD_READ;
			end else if (pick < 270) begin
				w.cmd = CMD_MARK;
			end else if (pick < 370) begin
				w.char_code = NEWLINE;
			end else if (pick < 400) begin
				w.char_code = NUL;
			end else if (pick >= 500) begin
				w.char_code = CHAR_W'($urandom_range(32, 126));
			end
			pending_words.push_back(w);
			if (!(w.cmd == CMD_WRITE && w.char_code == NUL)) counted++;
		end
	endtask

	initial begin
		logic [ROWCFG_W-1:0]  rows_pick;
		logic [SLOTCFG_W-1:0] slots_pick;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin rows_pick = ROWS_RST; slots_pick = SLOTS_RST; end
				1: begin rows_pick = 6'd2;  slots_pick = 8'd3;   end
				2: begin rows_pick = 6'd0;  slots_pick = 8'd0;   end
				3: begin rows_pick = 6'd63; slots_pick = 8'd255; end
				4: begin rows_pick = 6'd1;  slots_pick = 8'd128; end
				5: begin rows_pick = 6'd32; slots_pick = 8'd2;   end
				default: begin
					rows_pick  = ROWCFG_W'($urandom_range(1, 32));
					slots_pick = (p % 2) ? SLOTCFG_W'($urandom_range(2, 16)) :
						SLOTCFG_W'($urandom_range(17, 128));
				end
			endcase
			run_phase(p, rows_pick, slots_pick, p != 0);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && cursor_reports.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
